// ===== hdl/ppd_pkg.sv =====
// ppd_pkg: shared types and constants for the PPM pulse-train decoder.
// No dependencies.

package ppd_pkg;

    localparam int unsigned WIDTH_BITS   = 16;
    localparam int unsigned CHAN_BITS    = 4;
    localparam int unsigned LIVE_COUNT   = 4;
    localparam int unsigned LIVE_BITS    = 2;
    localparam logic [LIVE_COUNT-1:0] LIVE_FULL = 4'hF;

    localparam logic [WIDTH_BITS-1:0] RST_FAILSAFE_THRESHOLD = 16'd950;
    localparam logic [WIDTH_BITS-1:0] RST_SYNC_GAP           = 16'd2700;
    localparam logic [WIDTH_BITS-1:0] RST_MIN_PULSE          = 16'd750;
    localparam logic [WIDTH_BITS-1:0] RST_MAX_PULSE          = 16'd2250;

    typedef enum logic [1:0] {
        REG_FAILSAFE_THRESHOLD = 2'd0,
        REG_SYNC_GAP           = 2'd1,
        REG_MIN_PULSE          = 2'd2,
        REG_MAX_PULSE          = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] failsafe_threshold;
        logic [WIDTH_BITS-1:0] sync_gap;
        logic [WIDTH_BITS-1:0] min_pulse;
        logic [WIDTH_BITS-1:0] max_pulse;
    } cfg_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] pulse_width;
        logic                  channel_valid;
        logic [CHAN_BITS-1:0]  channel_index;
        logic                  frame_sync;
        logic                  link_good;
    } result_t;

endpackage

// ===== hdl/ppd_step.sv =====
// ppd_step: decoder state (previous edge, channel index, live mask) and the
// combinational classification of one edge. Depends on ppd_pkg.

module ppd_step #(
    parameter int unsigned NUM_CHANNELS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic [ppd_pkg::WIDTH_BITS-1:0]    edge_time,
    input  ppd_pkg::cfg_t                     cfg,
    output ppd_pkg::result_t                  result
);

    localparam logic [ppd_pkg::CHAN_BITS-1:0] NumCh = ppd_pkg::CHAN_BITS'(NUM_CHANNELS);

    logic [ppd_pkg::WIDTH_BITS-1:0] prev_edge_reg;
    logic [ppd_pkg::WIDTH_BITS-1:0] prev_edge_next;
    logic [ppd_pkg::CHAN_BITS-1:0]  next_chan_reg;
    logic [ppd_pkg::CHAN_BITS-1:0]  next_chan_next;
    logic [ppd_pkg::LIVE_COUNT-1:0] live_mask_reg;
    logic [ppd_pkg::LIVE_COUNT-1:0] live_mask_next;

    logic [ppd_pkg::WIDTH_BITS-1:0] width;
    logic                           is_sync;
    logic                           in_bounds;
    logic                           chan_free;
    logic                           store;
    logic [ppd_pkg::LIVE_COUNT-1:0] live_set;
    logic [ppd_pkg::LIVE_COUNT-1:0] live_upd;

    always_comb
    begin
        width     = edge_time - prev_edge_reg;
        is_sync   = width > cfg.sync_gap;
        in_bounds = (width > cfg.min_pulse) && (width < cfg.max_pulse);
        chan_free = next_chan_reg < NumCh;
        store     = !is_sync && in_bounds && chan_free;

        live_set = '0;
        if (next_chan_reg < ppd_pkg::CHAN_BITS'(ppd_pkg::LIVE_COUNT)
            && width > cfg.failsafe_threshold)
        begin
            live_set[next_chan_reg[ppd_pkg::LIVE_BITS-1:0]] = 1'b1;
        end
        live_upd = live_mask_reg | live_set;

        result.pulse_width   = width;
        result.channel_valid = store;
        result.channel_index = store ? next_chan_reg : '0;
        result.frame_sync    = is_sync;
        result.link_good     = store && (live_upd == ppd_pkg::LIVE_FULL);

        prev_edge_next = edge_time;
        next_chan_next = next_chan_reg;
        live_mask_next = live_mask_reg;
        if (is_sync)
        begin
            next_chan_next = '0;
        end
        else if (chan_free)
        begin
            next_chan_next = next_chan_reg + 1'b1;
        end
        if (store)
        begin
            live_mask_next = (live_upd == ppd_pkg::LIVE_FULL) ? '0 : live_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_edge_reg <= '0;
            next_chan_reg <= '0;
            live_mask_reg <= '0;
        end
        else if (advance)
        begin
            prev_edge_reg <= prev_edge_next;
            next_chan_reg <= next_chan_next;
            live_mask_reg <= live_mask_next;
        end
    end

endmodule

// ===== hdl/ppd_out_reg.sv =====
// ppd_out_reg: result register between the decode logic and the output channel.
// Depends on ppd_pkg.

module ppd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_ready,
    input  ppd_pkg::result_t  load_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ppd_pkg::result_t  out_data
);

    logic             valid_reg;
    logic             valid_next;
    ppd_pkg::result_t data_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load_valid || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== hdl/ppm_pulse_train_decoder.sv =====
// ppm_pulse_train_decoder: top level; configuration registers, input register,
// decode step and result register. Depends on ppd_pkg, ppd_step, ppd_out_reg.
//
// Usage:
//   Input channel (in_valid/in_ready, edge_time) takes one PPM edge timestamp
//   per item. Output channel (out_valid/out_ready) gives exactly one result per
//   item: pulse width, channel value flag and index, frame sync, link good.
//   Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
//   write only while no item is in flight.
//   Path: an accepted item waits in the input register, then its result is
//   loaded into the result register and presented.
//   Throughput: one item per cycle while out_ready is high; the decode loop on
//   channel index and live mask is combinational between the two registers.
//   Stall: with out_ready low the result register holds and one more item
//   is taken into the input register; in_ready then drops until out_ready.
//   Reset: registers return to their defaults (950, 2700, 750, 2250), the
//   previous edge time, channel index and live mask clear, no results pending.

module ppm_pulse_train_decoder #(
    parameter int unsigned NUM_CHANNELS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ppd_pkg::WIDTH_BITS-1:0]    edge_time,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ppd_pkg::WIDTH_BITS-1:0]    pulse_width,
    output logic                              channel_valid,
    output logic [ppd_pkg::CHAN_BITS-1:0]     channel_index,
    output logic                              frame_sync,
    output logic                              link_good,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [ppd_pkg::WIDTH_BITS-1:0]    cfg_data
);

    ppd_pkg::cfg_t                  cfg_reg;
    logic                           s1_valid_reg;
    logic [ppd_pkg::WIDTH_BITS-1:0] s1_edge_reg;
    logic                           s1_ready;
    logic                           s1_advance;
    ppd_pkg::result_t               step_result;
    ppd_pkg::result_t               out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.failsafe_threshold <= ppd_pkg::RST_FAILSAFE_THRESHOLD;
            cfg_reg.sync_gap           <= ppd_pkg::RST_SYNC_GAP;
            cfg_reg.min_pulse          <= ppd_pkg::RST_MIN_PULSE;
            cfg_reg.max_pulse          <= ppd_pkg::RST_MAX_PULSE;
        end
        else if (cfg_we)
        begin
            case (ppd_pkg::reg_index_t'(cfg_index))
                ppd_pkg::REG_FAILSAFE_THRESHOLD: cfg_reg.failsafe_threshold <= cfg_data;
                ppd_pkg::REG_SYNC_GAP:           cfg_reg.sync_gap           <= cfg_data;
                ppd_pkg::REG_MIN_PULSE:          cfg_reg.min_pulse          <= cfg_data;
                ppd_pkg::REG_MAX_PULSE:          cfg_reg.max_pulse          <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s1_advance = s1_valid_reg && s1_ready;
    assign in_ready   = !s1_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_edge_reg <= edge_time;
        end
    end

    ppd_step #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_advance),
        .edge_time (s1_edge_reg),
        .cfg       (cfg_reg),
        .result    (step_result)
    );

    ppd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid_reg),
        .load_ready (s1_ready),
        .load_data  (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign pulse_width   = out_data.pulse_width;
    assign channel_valid = out_data.channel_valid;
    assign channel_index = out_data.channel_index;
    assign frame_sync    = out_data.frame_sync;
    assign link_good     = out_data.link_good;

    a_good_needs_store: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && link_good) |-> channel_valid)
        else $error("link_good without a stored channel value");

    a_sync_clears_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_sync) |-> (!channel_valid && channel_index == '0))
        else $error("frame sync result carries a channel value");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && channel_valid)
            |-> (channel_index < ppd_pkg::CHAN_BITS'(NUM_CHANNELS)))
        else $error("channel index beyond channel count");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ready) |=> s1_valid_reg)
        else $error("pending item lost from input register");

endmodule

// ===== test/ppd_checker.sv =====
`timescale 1ns / 100ps
// ppd_checker: watches the channels and register writes of the PPM decoder,
// predicts each result and compares it with what the block returns.
// Depends on ppd_pkg.

module ppd_checker #(
    parameter int unsigned NUM_CHANNELS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [ppd_pkg::WIDTH_BITS-1:0] edge_time,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [ppd_pkg::WIDTH_BITS-1:0] pulse_width,
    input  logic                           channel_valid,
    input  logic [ppd_pkg::CHAN_BITS-1:0]  channel_index,
    input  logic                           frame_sync,
    input  logic                           link_good,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [ppd_pkg::WIDTH_BITS-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             checked_count,
    output int                             sync_count,
    output int                             channel_count,
    output int                             good_count
);

    localparam logic [ppd_pkg::CHAN_BITS-1:0] NUM_CH  = ppd_pkg::CHAN_BITS'(NUM_CHANNELS);
    localparam logic [ppd_pkg::CHAN_BITS-1:0] LIVE_CH = ppd_pkg::CHAN_BITS'(ppd_pkg::LIVE_COUNT);

    ppd_pkg::cfg_t                  cfg_q;
    logic [ppd_pkg::WIDTH_BITS-1:0] last_edge;
    logic [ppd_pkg::CHAN_BITS-1:0]  chan_next;
    logic [ppd_pkg::LIVE_COUNT-1:0] live_mask;
    ppd_pkg::result_t               decoded_q [$];
    ppd_pkg::result_t               predicted;
    ppd_pkg::result_t               seen;
    ppd_pkg::result_t               oldest;
    int                             errors;
    int                             checked;
    int                             syncs;
    int                             channels;
    int                             goods;

    task automatic decode_edge(input logic [ppd_pkg::WIDTH_BITS-1:0] t,
                               output ppd_pkg::result_t r);
        logic [ppd_pkg::WIDTH_BITS-1:0] w;
        w = t - last_edge;
        r = '0;
        r.pulse_width = w;
        last_edge = t;
        if (w > cfg_q.sync_gap)
        begin
            chan_next = '0;
            r.frame_sync = 1'b1;
        end
        else
        begin
            if (w > cfg_q.min_pulse && w < cfg_q.max_pulse && chan_next < NUM_CH)
            begin
                r.channel_valid = 1'b1;
                r.channel_index = chan_next;
                if (chan_next < LIVE_CH && w > cfg_q.failsafe_threshold)
                    live_mask[chan_next[ppd_pkg::LIVE_BITS-1:0]] = 1'b1;
                if (live_mask == ppd_pkg::LIVE_FULL)
                begin
                    live_mask = '0;
                    r.link_good = 1'b1;
                end
            end
            if (chan_next < NUM_CH)
                chan_next = chan_next + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_q.failsafe_threshold = ppd_pkg::RST_FAILSAFE_THRESHOLD;
            cfg_q.sync_gap           = ppd_pkg::RST_SYNC_GAP;
            cfg_q.min_pulse          = ppd_pkg::RST_MIN_PULSE;
            cfg_q.max_pulse          = ppd_pkg::RST_MAX_PULSE;
            last_edge = '0;
            chan_next = '0;
            live_mask = '0;
            decoded_q.delete();
            errors   = 0;
            checked  = 0;
            syncs    = 0;
            channels = 0;
            goods    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen.pulse_width   = pulse_width;
                seen.channel_valid = channel_valid;
                seen.channel_index = channel_index;
                seen.frame_sync    = frame_sync;
                seen.link_good     = link_good;
                checked++;
                syncs    += int'(seen.frame_sync);
                channels += int'(seen.channel_valid);
                goods    += int'(seen.link_good);
                if (decoded_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no item outstanding, expected none, got width %0d",
                             $time, seen.pulse_width);
                end
                else
                begin
                    oldest = decoded_q.pop_front();
                    check_field("pulse_width", 32'(oldest.pulse_width),
                                32'(seen.pulse_width));
                    check_field("channel_valid", 32'(oldest.channel_valid),
                                32'(seen.channel_valid));
                    check_field("channel_index", 32'(oldest.channel_index),
                                32'(seen.channel_index));
                    check_field("frame_sync", 32'(oldest.frame_sync),
                                32'(seen.frame_sync));
                    check_field("link_good", 32'(oldest.link_good),
                                32'(seen.link_good));
                end
            end
            if (cfg_we)
            begin
                case (ppd_pkg::reg_index_t'(cfg_index))
                    ppd_pkg::REG_FAILSAFE_THRESHOLD: cfg_q.failsafe_threshold = cfg_data;
                    ppd_pkg::REG_SYNC_GAP:           cfg_q.sync_gap           = cfg_data;
                    ppd_pkg::REG_MIN_PULSE:          cfg_q.min_pulse          = cfg_data;
                    ppd_pkg::REG_MAX_PULSE:          cfg_q.max_pulse          = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                decode_edge(edge_time, predicted);
                decoded_q.push_back(predicted);
            end
        end
        pending       <= decoded_q.size();
        fail_count    <= errors;
        checked_count <= checked;
        sync_count    <= syncs;
        channel_count <= channels;
        good_count    <= goods;
    end

endmodule

// ===== test/tb_ppm_pulse_train_decoder.sv =====
`timescale 1ns / 100ps
// tb_ppm_pulse_train_decoder: drives PPM edge timestamps and register settings
// into the decoder and gives the verdict. Depends on ppd_pkg,
// ppm_pulse_train_decoder and ppd_checker.

module tb_ppm_pulse_train_decoder;

    localparam int unsigned NUM_CHANNELS = 12;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASES       = 6;
    localparam int          N_DIRECTED   = 21;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic [ppd_pkg::WIDTH_BITS-1:0] edge_time = '0;
    logic                           out_ready = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [1:0]                     cfg_index = '0;
    logic [ppd_pkg::WIDTH_BITS-1:0] cfg_data  = '0;

    logic                           in_ready;
    logic                           out_valid;
    logic [ppd_pkg::WIDTH_BITS-1:0] pulse_width;
    logic                           channel_valid;
    logic [ppd_pkg::CHAN_BITS-1:0]  channel_index;
    logic                           frame_sync;
    logic                           link_good;

    int fail_count;
    int pending;
    int checked_count;
    int sync_count;
    int channel_count;
    int good_count;

    int send_idle_pct = 37;
    int recv_idle_pct = 75;
    int hold_requests = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int cycles        = 0;
    int edges_sent    = 0;

    logic [ppd_pkg::WIDTH_BITS-1:0] edge_now = '0;
    int cur_thr  = 950;
    int cur_sync = 2700;
    int cur_min  = 750;
    int cur_max  = 2250;

    // first edge is measured from time zero; frame syncs, live mask, bounds, overrun
    logic [ppd_pkg::WIDTH_BITS-1:0] directed_widths [N_DIRECTED] = '{
        16'd3000, 16'd950, 16'd951, 16'd1000, 16'd1000, 16'd2701, 16'd951,
        16'd751, 16'd2249, 16'd750, 16'd2250, 16'd0, 16'd1500, 16'd1500,
        16'd1500, 16'd1500, 16'd2700, 16'd1500, 16'd1500, 16'd1500, 16'd65535
    };
    int phase_len [PHASES] = '{250, 250, 120, 120, 250, 250};

    ppm_pulse_train_decoder #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .edge_time(edge_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pulse_width(pulse_width),
        .channel_valid(channel_valid),
        .channel_index(channel_index),
        .frame_sync(frame_sync),
        .link_good(link_good),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    ppd_checker #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .edge_time(edge_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pulse_width(pulse_width),
        .channel_valid(channel_valid),
        .channel_index(channel_index),
        .frame_sync(frame_sync),
        .link_good(link_good),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending),
        .checked_count(checked_count),
        .sync_count(sync_count),
        .channel_count(channel_count),
        .good_count(good_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_taken != hold_requests)
        begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [ppd_pkg::WIDTH_BITS-1:0] pick_between(input int lo, input int hi);
        if (lo > hi)
            return lo[ppd_pkg::WIDTH_BITS-1:0];
        return ppd_pkg::WIDTH_BITS'($urandom_range(hi, lo));
    endfunction

    function automatic logic [ppd_pkg::WIDTH_BITS-1:0] noise_width();
        logic [ppd_pkg::WIDTH_BITS-1:0] w;
        case ($urandom_range(10))
            0:       w = ppd_pkg::WIDTH_BITS'(cur_min);
            1:       w = ppd_pkg::WIDTH_BITS'(cur_min + 1);
            2:       w = ppd_pkg::WIDTH_BITS'(cur_max - 1);
            3:       w = ppd_pkg::WIDTH_BITS'(cur_max);
            4:       w = ppd_pkg::WIDTH_BITS'(cur_thr);
            5:       w = ppd_pkg::WIDTH_BITS'(cur_thr + 1);
            6:       w = ppd_pkg::WIDTH_BITS'(cur_sync);
            7:       w = ppd_pkg::WIDTH_BITS'(cur_sync + 1);
            8:       w = '0;
            9:       w = '1;
            default: w = ppd_pkg::WIDTH_BITS'($urandom_range(65535));
        endcase
        return w;
    endfunction

    function automatic logic [ppd_pkg::WIDTH_BITS-1:0] channel_width();
        int lo;
        int hi;
        if ($urandom_range(99) < 80 && cur_max > cur_min + 1)
        begin
            lo = cur_min + 1;
            hi = cur_max - 1;
            if ($urandom_range(1) == 1 && hi > cur_thr && cur_thr + 1 > lo)
                lo = cur_thr + 1;
            return pick_between(lo, hi);
        end
        return noise_width();
    endfunction

    task automatic send_item(input logic [ppd_pkg::WIDTH_BITS-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        edge_time <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        edges_sent++;
    endtask

    task automatic send_width(input logic [ppd_pkg::WIDTH_BITS-1:0] w);
        edge_now = edge_now + w;
        send_item(edge_now);
    endtask

    task automatic send_frame();
        int n;
        int top;
        if (cur_sync < 65535)
        begin
            top = ($urandom_range(1) == 1) ? 65535 : cur_sync + 3000;
            if (top > 65535)
                top = 65535;
            send_width(pick_between(cur_sync + 1, top));
        end
        n = $urandom_range(14, 1);
        repeat (n)
            send_width(channel_width());
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input ppd_pkg::reg_index_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[ppd_pkg::WIDTH_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic load_config(input int thr, input int sync, input int lo, input int hi);
        wait_drained();
        write_reg(ppd_pkg::REG_MAX_PULSE, hi);
        write_reg(ppd_pkg::REG_FAILSAFE_THRESHOLD, thr);
        write_reg(ppd_pkg::REG_MIN_PULSE, lo);
        write_reg(ppd_pkg::REG_SYNC_GAP, sync);
        cfg_we   <= 1'b0;
        cur_thr  = thr;
        cur_sync = sync;
        cur_min  = lo;
        cur_max  = hi;
    endtask

    initial
    begin
        int   p;
        int   i;
        int   phase_start;
        logic held;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            send_width(directed_widths[i]);
        end

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       load_config(950, 2700, 750, 2250);
                1:       load_config(1200, 3000, 900, 2100);
                2:       load_config(950, 2700, 1500, 1501);
                3:       load_config(0, 65535, 0, 65535);
                4:       load_config(int'($urandom_range(1400, 600)),
                                     int'($urandom_range(4000, 2300)),
                                     int'($urandom_range(1000, 500)),
                                     int'($urandom_range(2600, 1800)));
                default: load_config(950, 2700, 750, 2250);
            endcase
            if (p < 2)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 75;
            end
            else if (p < 4)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            held        = 1'b0;
            phase_start = edges_sent;
            while (edges_sent - phase_start < phase_len[p])
            begin
                if (!held && (p == 0 || p == 4)
                    && edges_sent - phase_start >= phase_len[p] / 2)
                begin
                    hold_requests++;
                    held = 1'b1;
                end
                send_frame();
            end
        end

        wait_drained();

        $display("Sent %0d edges, checked %0d results: %0d frame syncs, %0d channel values,",
                 edges_sent, checked_count, sync_count, channel_count);
        $display("%0d link-good pulses over six register settings and three stall patterns.",
                 good_count);
        if (checked_count != edges_sent)
        begin
            $display("%0t: result count mismatch, expected %0d, got %0d",
                     $time, edges_sent, checked_count);
        end
        if (fail_count == 0 && pending == 0 && checked_count == edges_sent)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ppd_pkg.sv
hdl/ppd_step.sv
hdl/ppd_out_reg.sv
hdl/ppm_pulse_train_decoder.sv
test/ppd_checker.sv
test/tb_ppm_pulse_train_decoder.sv
